// File: rtl/core/gmdm_pkg.sv
package gmdm_pkg;

  localparam int WEIGHT_BITS = 24;
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;

  localparam logic [WEIGHT_BITS-1:0] W_PAIR = 24'd11863283;

  typedef struct packed {
    logic             wr_en;
    logic             acc_init;
    logic             diag;
    logic             issue;
    logic             neg;
    logic             to_im;
    logic             off_diag;
    logic             scaled;
    logic [IDX_W-1:0] g;
    logic             out_load;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             final_e;
  } gmdm_cmd_t;

  // floor(2^24 / sqrt((g+1)(g+2))), optionally times (g+1)
  function automatic logic [WEIGHT_BITS-1:0] gmdm_weight(input logic [IDX_W-1:0] g,
                                                          input logic scaled);
    logic [WEIGHT_BITS-1:0] w;
    w = '0;
    case (g)
      3'd0: w = scaled ? 24'd11863283 : 24'd11863283;
      3'd1: w = scaled ? 24'd13698538 : 24'd6849269;
      3'd2: w = scaled ? 24'd14529495 : 24'd4843165;
      3'd3: w = scaled ? 24'd15005996 : 24'd3751499;
      3'd4: w = scaled ? 24'd15315430 : 24'd3063086;
      3'd5: w = scaled ? 24'd15532680 : 24'd2588780;
      3'd6: w = scaled ? 24'd15693643 : 24'd2241949;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/gmdm_ram.sv
module gmdm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 63
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gmdm_datapath.sv
module gmdm_datapath import gmdm_pkg::*; #(
  parameter int MAX_DIM     = 8,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [DIM_W-1:0]                       dim_i,
  input  gmdm_cmd_t                              cmd_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM-1)-1:0]   wr_addr_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM-1)-1:0]   rd_addr_i,
  input  logic [VALUE_WIDTH-1:0]                 coefficient_i,
  output logic [2:0]                             row_o,
  output logic [2:0]                             col_o,
  output logic [VALUE_WIDTH-1:0]                 real_part_o,
  output logic [VALUE_WIDTH-1:0]                 imag_part_o,
  output logic                                   final_entry_o
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM - 1;
  localparam int PROD_W      = VALUE_WIDTH + WEIGHT_BITS + 1;
  localparam int ACC_W       = VALUE_WIDTH + WEIGHT_BITS + 3;
  localparam int QW          = ACC_W - WEIGHT_BITS;
  localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (WEIGHT_BITS - 1);

  logic [VALUE_WIDTH-1:0]   ram_rdata;
  logic [ACC_W-1:0]         base_tab [2:MAX_DIM];
  logic [ACC_W-1:0]         base_val;
  logic [WEIGHT_BITS-1:0]   weight_sel;

  logic                     s1_valid_q, s2_valid_q;
  logic                     s1_neg_q, s1_im_q, s2_neg_q, s2_im_q;
  logic [WEIGHT_BITS-1:0]   s1_w_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [ACC_W-1:0]         term;
  logic [ACC_W-1:0]         acc_re_q, acc_im_q;

  logic [2:0]               row_q, col_q;
  logic [VALUE_WIDTH-1:0]   re_q, im_q;
  logic                     final_q;

  gmdm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (coefficient_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // 1/D at accumulator scale, rounded
  for (genvar gd = 2; gd <= MAX_DIM; gd++) begin : g_base
    localparam logic [63:0] BV =
      ((64'd1 << (VALUE_WIDTH - 2 + WEIGHT_BITS)) + 64'(gd / 2)) / 64'(gd);
    assign base_tab[gd] = BV[ACC_W-1:0];
  end

  always_comb begin
    base_val = '0;
    for (int k = 2; k <= MAX_DIM; k++) begin
      if (dim_i == DIM_W'(k)) begin
        base_val = base_tab[k];
      end
    end
  end

  assign weight_sel = cmd_i.off_diag ? W_PAIR : gmdm_weight(cmd_i.g, cmd_i.scaled);
  assign prod_d     = $signed(ram_rdata) * $signed({1'b0, s1_w_q});
  assign term       = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_neg_q <= cmd_i.neg;
    s1_im_q  <= cmd_i.to_im;
    s1_w_q   <= weight_sel;
    s2_neg_q <= s1_neg_q;
    s2_im_q  <= s1_im_q;
    prod_q   <= prod_d;
    if (cmd_i.acc_init) begin
      acc_re_q <= cmd_i.diag ? base_val : '0;
      acc_im_q <= '0;
    end else if (s2_valid_q) begin
      if (s2_im_q) begin
        acc_im_q <= s2_neg_q ? acc_im_q - term : acc_im_q + term;
      end else begin
        acc_re_q <= s2_neg_q ? acc_re_q - term : acc_re_q + term;
      end
    end
  end

  // round half up, drop weight fraction, saturate
  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0]       t;
    logic [QW-1:0]          q;
    logic [VALUE_WIDTH-1:0] r;
    t = acc + RND;
    q = t[ACC_W-1:WEIGHT_BITS];
    if (q[QW-1:VALUE_WIDTH-1] == '0 || q[QW-1:VALUE_WIDTH-1] == '1) begin
      r = q[VALUE_WIDTH-1:0];
    end else if (q[QW-1]) begin
      r = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      row_q   <= cmd_i.row;
      col_q   <= cmd_i.col;
      re_q    <= to_value(acc_re_q);
      im_q    <= to_value(acc_im_q);
      final_q <= cmd_i.final_e;
    end
  end

  assign row_o         = row_q;
  assign col_o         = col_q;
  assign real_part_o   = re_q;
  assign imag_part_o   = im_q;
  assign final_entry_o = final_q;

endmodule

// File: rtl/core/gmdm_ctrl.sv
module gmdm_ctrl import gmdm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [DIM_W-1:0]                     dim_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output gmdm_cmd_t                            cmd_o,
  output logic [$clog2(MAX_DIM*MAX_DIM-1)-1:0] wr_addr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM-1)-1:0] rd_addr_o
);

  localparam int AW    = $clog2(MAX_DIM * MAX_DIM - 1);
  localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, g_q, g_d;
  logic             tc_q, tc_d, drain_q, drain_d;
  logic             out_valid_q, out_valid_d;

  logic [7:0]       total;
  logic [CNT_W:0]   count_inc;
  logic [IDX_W-1:0] dm1, dm2, lo, hi;
  logic             diag, scaled, last_entry, out_free;
  logic [6:0]       pair7, addr7;

  assign total     = {4'b0, dim_i} * {4'b0, dim_i} - 8'd1;
  assign count_inc = {1'b0, count_q} + (CNT_W + 1)'(1);
  assign dm1       = IDX_W'(dim_i - DIM_W'(1));
  assign dm2       = IDX_W'(dim_i - DIM_W'(2));
  assign diag      = (i_q == j_q);
  assign lo        = (i_q < j_q) ? i_q : j_q;
  assign hi        = (i_q < j_q) ? j_q : i_q;
  assign scaled    = diag && (i_q != '0) && ((g_q + IDX_W'(1)) == i_q);
  assign last_entry = (i_q == dm1) && (j_q == dm1);
  assign out_free  = !out_valid_q || !out_stall_i;

  // upper-triangle pair number of (lo,hi)
  assign pair7 = 7'(lo) * 7'(dim_i) - ((7'(lo) * (7'(lo) + 7'd1)) >> 1)
                 + 7'(hi) - 7'(lo) - 7'd1;
  assign addr7 = diag ? 7'(dim_i) * (7'(dim_i) - 7'd1) + 7'(g_q)
                      : {pair7[5:0], tc_q};

  assign rd_addr_o   = addr7[AW-1:0];
  assign wr_addr_o   = count_q[AW-1:0];
  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    g_d         = g_q;
    tc_d        = tc_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    cmd_o          = '0;
    cmd_o.diag     = diag;
    cmd_o.off_diag = !diag;
    cmd_o.scaled   = scaled;
    cmd_o.g        = g_q;
    cmd_o.to_im    = !diag && tc_q;
    cmd_o.neg      = diag ? scaled : (tc_q && (i_q > j_q));
    cmd_o.row      = i_q;
    cmd_o.col      = j_q;
    cmd_o.final_e  = last_entry;

    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (8'(count_inc) >= total) begin
            count_d = '0;
            i_d     = '0;
            j_d     = '0;
            state_d = ST_INIT;
          end else begin
            count_d = count_inc[CNT_W-1:0];
          end
        end
      end
      ST_INIT: begin
        cmd_o.acc_init = 1'b1;
        tc_d           = 1'b0;
        g_d            = (i_q == '0) ? '0 : i_q - IDX_W'(1);
        state_d        = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (diag) begin
          if (g_q == dm2) begin
            drain_d = 1'b0;
            state_d = ST_DRAIN;
          end else begin
            g_d = g_q + IDX_W'(1);
          end
        end else if (tc_q) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end else begin
          tc_d = 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          if (last_entry) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_INIT;
            if (j_q == dm1) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      g_q         <= '0;
      tc_q        <= 1'b0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      g_q         <= g_d;
      tc_q        <= tc_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/gell_mann_density_matrix_rebuild_unit.sv
// Rebuilds a D x D density matrix from D*D-1 generalized Gell-Mann coefficients.
// Input channel (in_valid_i / in_stall_o): one signed coefficient per item,
// taken one per cycle while the block is loading. The item that completes a
// set (count reaches D*D-1) starts the rebuild; the input is stalled until
// the last matrix entry has been placed in the output register.
// Output channel (out_valid_o / out_stall_i): D*D entries in row-major order,
// final_entry_o set on entry (D-1,D-1). An entry is held while stalled; the
// next entry is computed meanwhile and waits for the output register.
// Each entry is formed by a single multiplier fed from one store read port:
// off-diagonal entries issue a real and an imaginary product, diagonal entry i
// one product per generator index from i-1 (0 for row 0) up to D-2.
// cfg_we_i / cfg_wdata_i write D; values below 2 act as 2 and values above
// MAX_DIM act as MAX_DIM. Write only while idle.
// Reset: D returns to 2, the load count to 0, and no output is pending.
// Store contents are not cleared; a load after reset or a finished set starts at entry 0.
module gell_mann_density_matrix_rebuild_unit import gmdm_pkg::*; #(
  parameter int MAX_DIM     = 8,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [DIM_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] coefficient_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             row_o,
  output logic [2:0]             col_o,
  output logic [VALUE_WIDTH-1:0] real_part_o,
  output logic [VALUE_WIDTH-1:0] imag_part_o,
  output logic                   final_entry_o
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM - 1);

  logic [DIM_W-1:0] dim_q, dim_eff;
  gmdm_cmd_t        cmd;
  logic [AW-1:0]    wr_addr, rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_W'(2);
    end else if (cfg_we_i) begin
      dim_q <= cfg_wdata_i;
    end
  end

  assign dim_eff = (dim_q < DIM_W'(2))       ? DIM_W'(2)       :
                   (dim_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_q;

  gmdm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dim_i       (dim_eff),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr)
  );

  gmdm_datapath #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dim_i         (dim_eff),
    .cmd_i         (cmd),
    .wr_addr_i     (wr_addr),
    .rd_addr_i     (rd_addr),
    .coefficient_i (coefficient_i),
    .row_o         (row_o),
    .col_o         (col_o),
    .real_part_o   (real_part_o),
    .imag_part_o   (imag_part_o),
    .final_entry_o (final_entry_o)
  );

endmodule

// File: verif/tb_top.sv
module tb_top;
  import gmdm_pkg::*;

  localparam int VW = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 100;
  localparam logic [VW-1:0] COEFF_MAX = 24'h7FFFFF;
  localparam logic [VW-1:0] COEFF_MIN = 24'h800000;

  typedef struct packed {
    logic [2:0]    row;
    logic [2:0]    col;
    logic [VW-1:0] re;
    logic [VW-1:0] im;
    logic          fin;
  } matrix_entry_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  class density_scoreboard;
    longint        coeff_mem[63];
    int            fill_cnt;
    logic [3:0]    dim_reg;
    matrix_entry_t expected_q[$];
    int            mismatches;
    int            entries_checked;
    int            matrices_seen;
    int            coeffs_seen;

    function new();
      dim_reg = 4'd2;
      fill_cnt = 0;
      mismatches = 0;
      entries_checked = 0;
      matrices_seen = 0;
      coeffs_seen = 0;
      foreach (coeff_mem[k]) coeff_mem[k] = 0;
    endfunction

    function int eff_dim(logic [3:0] v);
      if (v < 4'd2) return 2;
      if (v > 4'd8) return 8;
      return int'(v);
    endfunction

    // floor(2^24 / sqrt(n)) via integer square root of floor(2^48 / n)
    function longint gm_weight(longint unsigned n);
      longint unsigned x, res, b;
      x = (64'd1 << 48) / n;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function logic [VW-1:0] to_q(longint acc);
      longint t, q;
      t = acc + (longint'(1) <<< 23);
      q = t >>> 24;
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q[VW-1:0];
    endfunction

    function void note_coeff(logic [VW-1:0] v);
      int            d, total, i, j, k;
      longint        base, w, a, b, p;
      longint        re_acc[8][8];
      longint        im_acc[8][8];
      matrix_entry_t e;
      coeffs_seen++;
      if (fill_cnt < 63) coeff_mem[fill_cnt] = longint'($signed(v));
      fill_cnt = (fill_cnt + 1) % 64;
      d = eff_dim(dim_reg);
      total = d * d - 1;
      if (fill_cnt < total) return;
      fill_cnt = 0;
      base = ((longint'(1) <<< 46) + longint'(d / 2)) / longint'(d);
      for (i = 0; i < 8; i++)
        for (j = 0; j < 8; j++) begin
          re_acc[i][j] = (i == j) ? base : 0;
          im_acc[i][j] = 0;
        end
      k = 0;
      w = gm_weight(2);
      for (i = 0; i < d; i++)
        for (j = i + 1; j < d; j++) begin
          a = coeff_mem[k] * w;
          b = coeff_mem[k+1] * w;
          re_acc[i][j] += a;
          re_acc[j][i] += a;
          im_acc[i][j] += b;
          im_acc[j][i] -= b;
          k += 2;
        end
      for (i = 0; i + 1 < d; i++) begin
        w = gm_weight((i + 1) * (i + 2));
        p = coeff_mem[k] * w;
        for (j = 0; j <= i; j++) re_acc[j][j] += p;
        re_acc[i+1][i+1] -= p * longint'(i + 1);
        k++;
      end
      for (i = 0; i < d; i++)
        for (j = 0; j < d; j++) begin
          e.row = i[2:0];
          e.col = j[2:0];
          e.re = to_q(re_acc[i][j]);
          e.im = to_q(im_acc[i][j]);
          e.fin = (i == d - 1) && (j == d - 1);
          expected_q.push_back(e);
        end
    endfunction

    function void check_entry(matrix_entry_t got);
      matrix_entry_t want;
      if (expected_q.size() == 0) begin
        $error("entry (%0d,%0d) arrived with nothing pending", got.row, got.col);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      entries_checked++;
      if (got.fin === 1'b1) matrices_seen++;
      if (got.row !== want.row) begin
        $error("row: expected %0d, got %0d", want.row, got.row);
        mismatches++;
      end
      if (got.col !== want.col) begin
        $error("col: expected %0d, got %0d", want.col, got.col);
        mismatches++;
      end
      if (got.re !== want.re) begin
        $error("real_part: expected %0d, got %0d", $signed(want.re), $signed(got.re));
        mismatches++;
      end
      if (got.im !== want.im) begin
        $error("imag_part: expected %0d, got %0d", $signed(want.im), $signed(got.im));
        mismatches++;
      end
      if (got.fin !== want.fin) begin
        $error("final_entry: expected %0b, got %0b", want.fin, got.fin);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [DIM_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [VW-1:0]    coefficient_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [2:0]       row_o;
  logic [2:0]       col_o;
  logic [VW-1:0]    real_part_o;
  logic [VW-1:0]    imag_part_o;
  logic             final_entry_o;

  density_scoreboard sb;
  matrix_entry_t     out_entry;
  int                idle_cycles = 0;
  int                burst_left = 0;
  int                dim_writes = 0;
  int                random_sent = 0;
  bit                hold_req = 1'b0;
  int                hold_cnt = 0;
  int                mode_left = 0;
  int                period_cnt = 0;
  stall_mode_e       stall_mode = STALL_NONE;
  logic              stall_nx;

  gell_mann_density_matrix_rebuild_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .coefficient_i (coefficient_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_o         (row_o),
    .col_o         (col_o),
    .real_part_o   (real_part_o),
    .imag_part_o   (imag_part_o),
    .final_entry_o (final_entry_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_entry = '{row: row_o, col: col_o, re: real_part_o, im: imag_part_o,
                    fin: final_entry_o};
      sb.check_entry(out_entry);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt--;
      stall_nx = 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES - 1;
      stall_nx = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      period_cnt = (period_cnt + 1) % 3;
      case (stall_mode)
        STALL_NONE:  stall_nx = 1'b0;
        STALL_LIGHT: stall_nx = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: stall_nx = ($urandom_range(0, 3) != 0);
        default:     stall_nx = (period_cnt == 0);
      endcase
    end
    out_stall_i <= stall_nx;
  end

  function automatic logic [VW-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0:       return COEFF_MAX;
      1:       return COEFF_MIN;
      2:       return '0;
      3:       return VW'($urandom_range(0, 255)) - VW'(128);
      default: return VW'($urandom());
    endcase
  endfunction

  task automatic send_coeff(input logic [VW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    coefficient_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_coeff(v);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dim(input logic [DIM_W-1:0] v);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.dim_reg = v;
    dim_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_coeff(rand_coeff());
    random_sent += n;
  endtask

  initial begin
    logic [DIM_W-1:0] v;
    int               d, n;
    sb = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset dimension (2)
    send_coeff(COEFF_MAX);
    send_coeff(COEFF_MIN);
    send_coeff('0);
    // D=4: pairs at both extremes, diagonal weights all at max -> saturation
    write_dim(4'd4);
    for (n = 0; n < 12; n++) send_coeff(n[0] ? COEFF_MIN : COEFF_MAX);
    repeat (3) send_coeff(COEFF_MAX);
    // partial load at D=8 (15 clamps), then shrink: count already past D*D-1
    write_dim(4'd15);
    repeat (5) send_coeff(rand_coeff());
    write_dim(4'd0);
    send_coeff(rand_coeff());

    write_dim(4'd8);
    send_random(63);
    // long receiver hold-off while items keep coming
    write_dim(4'd2);
    hold_req = 1'b1;
    send_random(12);
    while (sb.coeffs_seen < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        8:       v = DIM_W'($urandom_range(5, 7));
        9:       v = DIM_W'($urandom_range(0, 1));
        default: v = DIM_W'($urandom_range(2, 4));
      endcase
      write_dim(v);
      d = sb.eff_dim(v);
      send_random($urandom_range(1, 3) * (d * d - 1));
      if ($urandom_range(0, 3) == 0) send_random($urandom_range(1, d * d - 2));
    end

    settle();
    $display("tb: %0d coefficients sent over %0d dimension writes (0..15, partial loads)",
             sb.coeffs_seen, dim_writes);
    $display("tb: %0d matrices, %0d entries checked, %0d mismatches",
             sb.matrices_seen, sb.entries_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
